// File: rtl/fra_pkg.sv
// Shared types and constants for the fraction arithmetic reduce core.
// Holds operation and status codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package fra_pkg;

    // Default operand width and the fixed widths of the result fields.
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int NUM_OUT_W       = 33;
    localparam int DEN_OUT_W       = 31;

    // Operation codes.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DEN_ZERO = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    // Which cross product the shared multiplier forms.
    typedef enum logic [1:0] {
        PROD_A,
        PROD_B,
        PROD_D
    } prod_sel_t;

    // Which kind of result is written to the output registers.
    typedef enum logic [1:0] {
        RES_OK,
        RES_ZERO,
        RES_ERR_DEN,
        RES_ERR_DIV
    } res_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      mul_en;
        prod_sel_t mul_sel;
        logic      combine;
        logic      gcd_init;
        logic      gcd_step;
        logic      gcd_fin;
        logic      div_init;
        logic      div_sel_den;
        logic      div_step;
        logic      div_save;
        logic      emit;
        res_kind_t emit_kind;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic den_zero;
        logic div_zero;
        logic num_zero;
        logic gcd_done;
        logic div_last;
    } stat_t;

endpackage

`default_nettype wire

// File: rtl/fra_dp.sv
// Datapath of the fraction arithmetic reduce core: operand registers, shared
// multiplier, binary GCD unit, restoring divider and result registers.
// Depends on fra_pkg.
`default_nettype none

module fra_dp #(
    parameter int VALUE_WIDTH = fra_pkg::VALUE_WIDTH_DEF
) (
    input  wire                              clk,
    input  wire  fra_pkg::cmd_t              cmd,
    output fra_pkg::stat_t                   stat,
    input  wire  [1:0]                       req_type,
    input  wire  signed [VALUE_WIDTH-1:0]    first_numerator,
    input  wire  signed [VALUE_WIDTH-1:0]    first_denominator,
    input  wire  signed [VALUE_WIDTH-1:0]    second_numerator,
    input  wire  signed [VALUE_WIDTH-1:0]    second_denominator,
    output logic signed [fra_pkg::NUM_OUT_W-1:0] result_numerator,
    output logic [fra_pkg::DEN_OUT_W-1:0]    result_denominator,
    output logic [1:0]                       status
);

    localparam int VW   = VALUE_WIDTH;
    localparam int PW   = 2 * VW;
    localparam int MW   = PW;
    localparam int CW   = $clog2(MW);
    localparam int NEXT = (MW + 1 > fra_pkg::NUM_OUT_W) ? MW + 1 : fra_pkg::NUM_OUT_W;
    localparam int DEXT = (MW > fra_pkg::DEN_OUT_W) ? MW : fra_pkg::DEN_OUT_W;

    // Operand registers.
    logic [1:0]           op_reg;
    logic signed [VW-1:0] n1_reg, d1_reg, n2_reg, d2_reg;

    // Products and combined numerator.
    logic signed [PW-1:0] pa_reg, pb_reg, pd_reg;
    logic signed [PW:0]   num_reg;
    logic                 neg_reg;

    // GCD state.
    logic [MW-1:0] ga_reg, gb_reg, g_reg;
    logic [CW-1:0] gk_reg;

    // Divider state.
    logic [MW-1:0] dq_reg;
    logic [MW:0]   dr_reg;
    logic [CW-1:0] dc_reg;
    logic [MW-1:0] qn_reg;

    // Result registers.
    logic signed [fra_pkg::NUM_OUT_W-1:0] res_num_reg;
    logic [fra_pkg::DEN_OUT_W-1:0]        res_den_reg;
    logic [1:0]                           res_st_reg;

    logic signed [VW-1:0] mul_x, mul_y;
    logic signed [PW-1:0] mul_p;
    logic signed [PW:0]   num_next;
    logic signed [PW:0]   num_abs;
    logic signed [PW-1:0] den_abs;
    logic [MW:0]          div_shift;
    logic                 div_ge;
    logic [NEXT-1:0]      qn_ext, qn_signed;
    logic [DEXT-1:0]      qd_ext;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (cmd.mul_sel)
            fra_pkg::PROD_A:
            begin
                mul_x = n1_reg;
                mul_y = (op_reg == fra_pkg::OP_MUL) ? n2_reg : d2_reg;
            end
            fra_pkg::PROD_B:
            begin
                mul_x = n2_reg;
                mul_y = d1_reg;
            end
            default:
            begin
                mul_x = d1_reg;
                mul_y = (op_reg == fra_pkg::OP_DIV) ? n2_reg : d2_reg;
            end
        endcase
    end

    assign mul_p = PW'(mul_x) * PW'(mul_y);

    // Numerator from the cross products.
    always_comb
    begin
        case (op_reg)
            fra_pkg::OP_ADD: num_next = (PW+1)'(pa_reg) + (PW+1)'(pb_reg);
            fra_pkg::OP_SUB: num_next = (PW+1)'(pa_reg) - (PW+1)'(pb_reg);
            default:         num_next = (PW+1)'(pa_reg);
        endcase
    end

    // Magnitudes of the unreduced numerator and denominator.
    assign num_abs = num_reg[PW] ? -num_reg : num_reg;
    assign den_abs = pd_reg[PW-1] ? -pd_reg : pd_reg;

    // One restoring division step.
    assign div_shift = {dr_reg[MW-1:0], dq_reg[MW-1]};
    assign div_ge    = (div_shift >= {1'b0, g_reg});

    // Status toward the controller.
    assign stat.den_zero = (d1_reg == '0) || (d2_reg == '0);
    assign stat.div_zero = (op_reg == fra_pkg::OP_DIV) && (n2_reg == '0);
    assign stat.num_zero = (num_reg == '0);
    assign stat.gcd_done = (ga_reg == gb_reg);
    assign stat.div_last = (dc_reg == CW'(MW - 1));

    // Signed and masked result fields.
    assign qn_ext    = NEXT'(qn_reg);
    assign qn_signed = neg_reg ? (~qn_ext + NEXT'(1)) : qn_ext;
    assign qd_ext    = DEXT'(dq_reg);

    // Operand, product and numerator registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= req_type;
            n1_reg <= first_numerator;
            d1_reg <= first_denominator;
            n2_reg <= second_numerator;
            d2_reg <= second_denominator;
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                fra_pkg::PROD_A: pa_reg <= mul_p;
                fra_pkg::PROD_B: pb_reg <= mul_p;
                default:         pd_reg <= mul_p;
            endcase
        end
        if (cmd.combine)
        begin
            num_reg <= num_next;
        end
    end

    // Binary GCD: strip common twos, then subtract and halve.
    always_ff @(posedge clk)
    begin
        if (cmd.gcd_init)
        begin
            ga_reg  <= num_abs[MW-1:0];
            gb_reg  <= den_abs[MW-1:0];
            gk_reg  <= '0;
            neg_reg <= num_reg[PW] ^ pd_reg[PW-1];
        end
        else if (cmd.gcd_step)
        begin
            if (!ga_reg[0] && !gb_reg[0])
            begin
                ga_reg <= ga_reg >> 1;
                gb_reg <= gb_reg >> 1;
                gk_reg <= gk_reg + CW'(1);
            end
            else if (!ga_reg[0])
            begin
                ga_reg <= ga_reg >> 1;
            end
            else if (!gb_reg[0])
            begin
                gb_reg <= gb_reg >> 1;
            end
            else if (ga_reg > gb_reg)
            begin
                ga_reg <= (ga_reg - gb_reg) >> 1;
            end
            else
            begin
                gb_reg <= (gb_reg - ga_reg) >> 1;
            end
        end
        if (cmd.gcd_fin)
        begin
            g_reg <= ga_reg << gk_reg;
        end
    end

    // Restoring divider by the GCD, one quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.div_save)
        begin
            qn_reg <= dq_reg;
        end
        if (cmd.div_init)
        begin
            dq_reg <= cmd.div_sel_den ? den_abs[MW-1:0] : num_abs[MW-1:0];
            dr_reg <= '0;
            dc_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg <= {dq_reg[MW-2:0], div_ge};
            dr_reg <= div_ge ? (div_shift - {1'b0, g_reg}) : div_shift;
            dc_reg <= dc_reg + CW'(1);
        end
    end

    // Result registers, written once per transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.emit_kind)
                fra_pkg::RES_OK:
                begin
                    res_num_reg <= qn_signed[fra_pkg::NUM_OUT_W-1:0];
                    res_den_reg <= qd_ext[fra_pkg::DEN_OUT_W-1:0];
                    res_st_reg  <= fra_pkg::ST_OK;
                end
                fra_pkg::RES_ZERO:
                begin
                    res_num_reg <= '0;
                    res_den_reg <= fra_pkg::DEN_OUT_W'(1);
                    res_st_reg  <= fra_pkg::ST_OK;
                end
                fra_pkg::RES_ERR_DEN:
                begin
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                    res_st_reg  <= fra_pkg::ST_DEN_ZERO;
                end
                default:
                begin
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                    res_st_reg  <= fra_pkg::ST_DIV_ZERO;
                end
            endcase
        end
    end

    assign result_numerator   = res_num_reg;
    assign result_denominator = res_den_reg;
    assign status             = res_st_reg;

endmodule

`default_nettype wire

// File: rtl/fra_ctrl.sv
// Controller of the fraction arithmetic reduce core: sequences the checks,
// products, GCD and the two divisions, and raises the done strobe.
// Depends on fra_pkg.
`default_nettype none

module fra_ctrl (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            start,
    output logic           busy,
    output logic           done,
    output fra_pkg::cmd_t  cmd,
    input  wire fra_pkg::stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_A,
        S_MUL_B,
        S_MUL_D,
        S_COMBINE,
        S_MAG,
        S_GCD,
        S_DIVN_INIT,
        S_DIVN,
        S_DIVD_INIT,
        S_DIVD,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.den_zero)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = fra_pkg::RES_ERR_DEN;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (stat.div_zero)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = fra_pkg::RES_ERR_DIV;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = fra_pkg::PROD_A;
                state_next  = S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = fra_pkg::PROD_B;
                state_next  = S_MUL_D;
            end
            S_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = fra_pkg::PROD_D;
                state_next  = S_COMBINE;
            end
            S_COMBINE:
            begin
                cmd.combine = 1'b1;
                state_next  = S_MAG;
            end
            S_MAG:
            begin
                if (stat.num_zero)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = fra_pkg::RES_ZERO;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.gcd_init = 1'b1;
                    state_next   = S_GCD;
                end
            end
            S_GCD:
            begin
                if (stat.gcd_done)
                begin
                    cmd.gcd_fin = 1'b1;
                    state_next  = S_DIVN_INIT;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIVN_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIVN;
            end
            S_DIVN:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_DIVD_INIT;
                end
            end
            S_DIVD_INIT:
            begin
                cmd.div_save    = 1'b1;
                cmd.div_init    = 1'b1;
                cmd.div_sel_den = 1'b1;
                state_next      = S_DIVD;
            end
            S_DIVD:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = fra_pkg::RES_OK;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and done strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

// File: rtl/fraction_arithmetic_reduce_core.sv
// Errors are reported from the check state and a zero numerator after the products,
// both without the GCD and the divisions. One transaction at a time: busy is low
// again in the cycle that done is high. The two restoring divisions by the GCD
// and the binary GCD loop take most of the time of a transaction. rst_n clears the
// controller asynchronously; results are valid only while done is high.
`default_nettype none

module fraction_arithmetic_reduce_core #(
    parameter int VALUE_WIDTH = fra_pkg::VALUE_WIDTH_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire  [1:0]                        req_type,
    input  wire  signed [VALUE_WIDTH-1:0]     first_numerator,
    input  wire  signed [VALUE_WIDTH-1:0]     first_denominator,
    input  wire  signed [VALUE_WIDTH-1:0]     second_numerator,
    input  wire  signed [VALUE_WIDTH-1:0]     second_denominator,
    output logic                              done,
    output logic signed [fra_pkg::NUM_OUT_W-1:0] result_numerator,
    output logic [fra_pkg::DEN_OUT_W-1:0]     result_denominator,
    output logic [1:0]                        status
);

    fra_pkg::cmd_t  cmd;
    fra_pkg::stat_t stat;

    // Sequencer.
    fra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Arithmetic and result registers.
    fra_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk                (clk),
        .cmd                (cmd),
        .stat               (stat),
        .req_type           (req_type),
        .first_numerator    (first_numerator),
        .first_denominator  (first_denominator),
        .second_numerator   (second_numerator),
        .second_denominator (second_denominator),
        .result_numerator   (result_numerator),
        .result_denominator (result_denominator),
        .status             (status)
    );

endmodule

`default_nettype wire
